// ----- design/msw_pkg.sv -----
// Shared types and constants for the multi-slot heartbeat watchdog.
// Holds the item structs, command/status/state codes and the table write bundle.
// No dependencies.
package msw_pkg;

   localparam int MSW_SLOTS = 16;
   localparam int SLOT_W    = 4;
   localparam int TMO_W     = 31;
   localparam int TIME_W    = 32;
   // wide enough for any slot index or slot count up to 256
   localparam int WIDE_W    = 9;

   localparam logic [TMO_W-1:0] DEFAULT_TMO_RESET = 31'd5000;

   typedef enum logic [1:0] {
      CMD_REGISTER   = 2'd0,
      CMD_UNREGISTER = 2'd1,
      CMD_PET        = 2'd2,
      CMD_CHECK      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_DONE     = 2'd0,
      STAT_DISABLED = 2'd1,
      STAT_IGNORED  = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_ENABLE          = 1'b0,
      CSR_DEFAULT_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_RESP = 2'd2
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [SLOT_W-1:0]  slot;
      logic [TMO_W-1:0]   timeout;
      logic [TIME_W-1:0]  now_ms;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  given_slot;
      logic               hang_found;
      logic [SLOT_W-1:0]  hang_slot;
   } rsp_item_type;

   // write side of the slot table
   typedef struct packed {
      logic               clear_all;
      logic               act_set;
      logic               act_clr;
      logic               beat_we;
      logic               tmo_we;
      logic [TIME_W-1:0]  beat_data;
      logic [TMO_W-1:0]   tmo_data;
   } tbl_wr_type;

endpackage

// ----- design/msw_table.sv -----
// Slot table: active flags in flip-flops, heartbeat times and timeouts in
// synchronous memories with a registered read port. Uses msw_pkg.
module msw_table import msw_pkg::*; #(
   parameter int SLOTS = MSW_SLOTS,
   parameter int IDX_W = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  tbl_wr_type         wr,
   input  logic [IDX_W-1:0]   wr_idx,
   input  logic [IDX_W-1:0]   rd_idx,
   input  logic [IDX_W-1:0]   act_idx,
   output logic               act_bit,
   output logic [TIME_W-1:0]  beat_q,
   output logic [TMO_W-1:0]   tmo_q
);

   logic [SLOTS-1:0]  active_ff;
   logic [SLOTS-1:0]  active_in;
   logic [TIME_W-1:0] beat_mem_ff [SLOTS];
   logic [TMO_W-1:0]  tmo_mem_ff  [SLOTS];
   logic [TIME_W-1:0] beat_q_ff;
   logic [TMO_W-1:0]  tmo_q_ff;

   // update active flags: clear all on enable, else set or drop one
   always_comb begin
      active_in = active_ff;
      if (wr.clear_all) begin
         active_in = '0;
      end else begin
         if (wr.act_set) begin
            active_in[wr_idx] = 1'b1;
         end
         if (wr.act_clr) begin
            active_in[wr_idx] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   assign act_bit = active_ff[act_idx];

   // heartbeat memory
   always_ff @(posedge clock) begin
      if (wr.beat_we) begin
         beat_mem_ff[wr_idx] <= wr.beat_data;
      end
      beat_q_ff <= beat_mem_ff[rd_idx];
   end

   // timeout memory
   always_ff @(posedge clock) begin
      if (wr.tmo_we) begin
         tmo_mem_ff[wr_idx] <= wr.tmo_data;
      end
      tmo_q_ff <= tmo_mem_ff[rd_idx];
   end

   assign beat_q = beat_q_ff;
   assign tmo_q  = tmo_q_ff;

endmodule

// ----- design/msw_ctrl.sv -----
// Command sequencer: config registers, slot scan, hang compare and the
// result register. Uses msw_pkg; drives the msw_table ports.
module msw_ctrl import msw_pkg::*; #(
   parameter int SLOTS = MSW_SLOTS,
   parameter int IDX_W = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_item_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_item_type       rsp_data,
   input  logic               csr_we,
   input  csr_index_type      csr_index,
   input  logic [TMO_W-1:0]   csr_wdata,
   output tbl_wr_type         tbl_wr,
   output logic [IDX_W-1:0]   tbl_wr_idx,
   output logic [IDX_W-1:0]   tbl_rd_idx,
   output logic [IDX_W-1:0]   tbl_act_idx,
   input  logic               tbl_act_bit,
   input  logic [TIME_W-1:0]  tbl_beat_q,
   input  logic [TMO_W-1:0]   tbl_tmo_q
);

   localparam int CNT_W = $clog2(SLOTS + 1);

   state_type          state_ff, state_in;
   logic               enable_ff, enable_in;
   logic [TMO_W-1:0]   dflt_tmo_ff, dflt_tmo_in;
   cmd_type            cmd_ff, cmd_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TMO_W-1:0]   tmo_ff, tmo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   rsp_item_type       res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               out_free;
   logic               scan_done;
   logic [WIDE_W-1:0]  slot_wide;
   logic               slot_in_range;
   logic [IDX_W-1:0]   slot_idx;
   logic [IDX_W-1:0]   cnt_idx;
   logic [WIDE_W-1:0]  cnt_wide;
   logic [WIDE_W-1:0]  cmp_wide;
   logic [TIME_W-1:0]  elapsed;
   logic               issue;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign slot_wide     = WIDE_W'(req_data.slot);
   assign slot_in_range = (slot_wide < WIDE_W'(SLOTS));
   assign slot_idx      = slot_wide[IDX_W-1:0];
   assign cnt_idx       = cnt_ff[IDX_W-1:0];
   assign cnt_wide      = WIDE_W'(cnt_idx);
   assign cmp_wide      = WIDE_W'(cmp_idx_ff);
   assign elapsed       = now_ff - tbl_beat_q;
   assign issue         = (cnt_ff < CNT_W'(SLOTS));

   // config registers; enabling also wipes the active flags
   always_comb begin
      enable_in   = enable_ff;
      dflt_tmo_in = dflt_tmo_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:          enable_in   = csr_wdata[0];
            CSR_DEFAULT_TIMEOUT: dflt_tmo_in = csr_wdata;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!enable_ff) begin
                  state_in = S_RESP;
               end else if (req_data.cmd == CMD_REGISTER ||
                            req_data.cmd == CMD_CHECK) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and table access per state
   always_comb begin
      cmd_in      = cmd_ff;
      now_in      = now_ff;
      tmo_in      = tmo_ff;
      cnt_in      = cnt_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      res_in      = res_ff;
      scan_done   = 1'b0;
      tbl_wr      = '0;
      tbl_wr.clear_all = csr_we & (csr_index == CSR_ENABLE) & csr_wdata[0];
      tbl_wr.beat_data = now_ff;
      tbl_wr.tmo_data  = tmo_ff;
      tbl_wr_idx  = cnt_idx;
      tbl_rd_idx  = cnt_idx;
      tbl_act_idx = cnt_idx;
      unique case (state_ff)
         S_IDLE: begin
            tbl_act_idx = slot_idx;
            tbl_wr_idx  = slot_idx;
            if (accept) begin
               // capture the item and act on unregister and pet at once
               cmd_in = req_data.cmd;
               now_in = req_data.now_ms;
               tmo_in = (req_data.timeout != '0) ? req_data.timeout : dflt_tmo_ff;
               cnt_in = '0;
               res_in = '{status: STAT_DONE, given_slot: '0, hang_found: 1'b0,
                          hang_slot: '0};
               if (!enable_ff) begin
                  res_in.status = STAT_DISABLED;
               end else begin
                  unique case (req_data.cmd)
                     CMD_UNREGISTER: begin
                        if (slot_in_range && tbl_act_bit) begin
                           tbl_wr.act_clr = 1'b1;
                        end else begin
                           res_in.status = STAT_IGNORED;
                        end
                     end
                     CMD_PET: begin
                        tbl_wr.beat_data = req_data.now_ms;
                        if (slot_in_range && tbl_act_bit) begin
                           tbl_wr.beat_we = 1'b1;
                        end else begin
                           res_in.status = STAT_IGNORED;
                        end
                     end
                     CMD_REGISTER, CMD_CHECK: begin
                     end
                  endcase
               end
            end
         end
         S_SCAN: begin
            if (cmd_ff == CMD_REGISTER) begin
               // walk the active flags for the lowest free slot
               if (!tbl_act_bit) begin
                  tbl_wr.act_set     = 1'b1;
                  tbl_wr.beat_we     = 1'b1;
                  tbl_wr.tmo_we      = 1'b1;
                  res_in.given_slot  = cnt_wide[SLOT_W-1:0];
                  scan_done          = 1'b1;
               end else if (cnt_ff == CNT_W'(SLOTS - 1)) begin
                  res_in.status = STAT_IGNORED;
                  scan_done     = 1'b1;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end else begin
               // issue one read per cycle, compare the slot read last cycle
               tbl_act_idx = cmp_idx_ff;
               cmp_vld_in  = issue;
               cmp_idx_in  = cnt_idx;
               if (issue) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (cmp_vld_ff && tbl_act_bit && (elapsed > TIME_W'(tbl_tmo_q))) begin
                  res_in.hang_found = 1'b1;
                  res_in.hang_slot  = cmp_wide[SLOT_W-1:0];
                  scan_done         = 1'b1;
               end else if (cmp_vld_ff && cmp_idx_ff == IDX_W'(SLOTS - 1)) begin
                  scan_done = 1'b1;
               end
            end
         end
         S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // result register toward the output side
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == S_RESP && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b0;
         dflt_tmo_ff  <= DEFAULT_TMO_RESET;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         dflt_tmo_ff  <= dflt_tmo_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      now_ff      <= now_in;
      tmo_ff      <= tmo_in;
      cnt_ff      <= cnt_in;
      cmp_idx_ff  <= cmp_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/multi_slot_heartbeat_watchdog.sv -----
// Top level of the multi-slot heartbeat watchdog.
// Joins the command sequencer (msw_ctrl) and the slot table (msw_table); uses msw_pkg.
//
// One item is handled at a time. Unregister and pet act in the cycle they are
// accepted, and the result goes through the result register to the output
// register. Register walks the active flags one slot per cycle up to the
// lowest free slot. Check reads one slot per cycle from the table memory port
// and compares it in the next cycle, stopping at the first hung slot. A new
// item is taken once the previous result has moved to the output register,
// even while that result still waits on rsp_stall.
module multi_slot_heartbeat_watchdog import msw_pkg::*; #(
   parameter int SLOTS = MSW_SLOTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_item_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_item_type       rsp_data,
   input  logic               csr_we,
   input  csr_index_type      csr_index,
   input  logic [TMO_W-1:0]   csr_wdata
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   tbl_wr_type         tbl_wr;
   logic [IDX_W-1:0]   tbl_wr_idx;
   logic [IDX_W-1:0]   tbl_rd_idx;
   logic [IDX_W-1:0]   tbl_act_idx;
   logic               tbl_act_bit;
   logic [TIME_W-1:0]  tbl_beat_q;
   logic [TMO_W-1:0]   tbl_tmo_q;

   // sequence commands and hold the result
   msw_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .tbl_wr      (tbl_wr),
      .tbl_wr_idx  (tbl_wr_idx),
      .tbl_rd_idx  (tbl_rd_idx),
      .tbl_act_idx (tbl_act_idx),
      .tbl_act_bit (tbl_act_bit),
      .tbl_beat_q  (tbl_beat_q),
      .tbl_tmo_q   (tbl_tmo_q)
   );

   // hold per-slot state
   msw_table #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .wr_idx  (tbl_wr_idx),
      .rd_idx  (tbl_rd_idx),
      .act_idx (tbl_act_idx),
      .act_bit (tbl_act_bit),
      .beat_q  (tbl_beat_q),
      .tmo_q   (tbl_tmo_q)
   );

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for multi_slot_heartbeat_watchdog: command items in,
// replies checked against a local mirror of the slot table.
// Depends on msw_pkg and the watchdog RTL only.
module tb import msw_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // Mirror of the slot table; predicts each reply and holds the ones still due
   class watchdog_mirror;
      bit                 enabled;
      logic [TMO_W-1:0]   fallback_tmo;
      bit                 active [MSW_SLOTS];
      logic [TIME_W-1:0]  last_beat_at [MSW_SLOTS];
      logic [TMO_W-1:0]   limit_ms [MSW_SLOTS];
      rsp_item_type       awaited [$];
      int                 errors;

      function new();
         enabled = 1'b0;
         fallback_tmo = DEFAULT_TMO_RESET;
         foreach (active[k]) active[k] = 1'b0;
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [TMO_W-1:0] value);
         case (idx)
            CSR_ENABLE: begin
               // enabling always empties the table
               enabled = value[0];
               if (value[0]) foreach (active[k]) active[k] = 1'b0;
            end
            CSR_DEFAULT_TIMEOUT: begin
               fallback_tmo = value;
            end
            default: ;
         endcase
      endfunction

      task report(string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      // Apply one accepted command and queue the reply it must produce
      function void note_command(req_item_type item);
         rsp_item_type      want;
         logic [TIME_W-1:0] elapsed;
         bit                done;
         want = '0;
         want.status = STAT_DONE;
         done = 1'b0;
         if (!enabled) begin
            want.status = STAT_DISABLED;
         end else begin
            case (item.cmd)
               CMD_REGISTER: begin
                  // claim the lowest free slot
                  want.status = STAT_IGNORED;
                  for (int k = 0; k < MSW_SLOTS && !done; k++) begin
                     if (!active[k]) begin
                        active[k] = 1'b1;
                        last_beat_at[k] = item.now_ms;
                        limit_ms[k] = (item.timeout != '0) ? item.timeout : fallback_tmo;
                        want.given_slot = k[SLOT_W-1:0];
                        want.status = STAT_DONE;
                        done = 1'b1;
                     end
                  end
               end
               CMD_UNREGISTER, CMD_PET: begin
                  if (!active[item.slot]) begin
                     want.status = STAT_IGNORED;
                  end else if (item.cmd == CMD_UNREGISTER) begin
                     active[item.slot] = 1'b0;
                  end else begin
                     last_beat_at[item.slot] = item.now_ms;
                  end
               end
               default: begin
                  // find the lowest slot whose wrapped age exceeds its limit
                  for (int k = 0; k < MSW_SLOTS && !done; k++) begin
                     elapsed = item.now_ms - last_beat_at[k];
                     if (active[k] && elapsed > {1'b0, limit_ms[k]}) begin
                        want.hang_found = 1'b1;
                        want.hang_slot = k[SLOT_W-1:0];
                        done = 1'b1;
                     end
                  end
               end
            endcase
         end
         awaited.push_back(want);
      endfunction

      // Compare one accepted reply with the oldest one due
      task check_reply(rsp_item_type got);
         rsp_item_type want;
         if (awaited.size() == 0) begin
            report("reply with no command outstanding");
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.given_slot !== want.given_slot)
            report($sformatf("given_slot got %0d want %0d", got.given_slot, want.given_slot));
         if (got.hang_found !== want.hang_found)
            report($sformatf("hang_found got %0b want %0b", got.hang_found, want.hang_found));
         if (got.hang_slot !== want.hang_slot)
            report($sformatf("hang_slot got %0d want %0d", got.hang_slot, want.hang_slot));
      endtask
   endclass

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BURSTY
   } stall_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_item_type       req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_item_type       rsp_data;
   logic               csr_we = 1'b0;
   csr_index_type      csr_index = CSR_ENABLE;
   logic [TMO_W-1:0]   csr_wdata = '0;

   watchdog_mirror     board = new();
   logic [TIME_W-1:0]  now_tick;
   stall_mode_type     stall_mode = STALL_NONE;
   int                 mode_left = 0;

   multi_slot_heartbeat_watchdog dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Check accepted replies; switch the stall pattern every so often
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) board.check_reply(rsp_data);
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         mode_left <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
         default:      rsp_stall <= ((mode_left % 24) < 18);
      endcase
   end

   // Hold one command item until the block takes it
   task automatic send_fields(input cmd_type c, input logic [SLOT_W-1:0] s,
                              input logic [TMO_W-1:0] t, input logic [TIME_W-1:0] n);
      req_item_type item;
      item.cmd = c;
      item.slot = s;
      item.timeout = t;
      item.now_ms = n;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_command(item);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stop sending until every reply is in, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.awaited.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [TMO_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random command: mostly a plausible time line with live slots, some noise
   task automatic send_random();
      int                 pick;
      cmd_type            c;
      logic [SLOT_W-1:0]  s;
      logic [TMO_W-1:0]   t;
      logic [TIME_W-1:0]  n;
      pick = $urandom_range(0, 99);
      if (pick < 30) c = CMD_REGISTER;
      else if (pick < 45) c = CMD_UNREGISTER;
      else if (pick < 70) c = CMD_PET;
      else c = CMD_CHECK;
      s = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, 15))
                                      : SLOT_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 30) t = '0;
      else if (pick < 70) t = TMO_W'($urandom_range(1, 100));
      else if (pick < 85) t = TMO_W'($urandom_range(101, 2000));
      else t = TMO_W'($urandom);
      now_tick = now_tick + TIME_W'($urandom_range(0, 30));
      n = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : now_tick;
      send_fields(c, s, t, n);
   endtask

   initial begin
      int burst_left;
      int items;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Disabled after reset: every command answers disabled
      send_fields(CMD_CHECK, 4'd0, '0, 32'd0);
      send_fields(CMD_REGISTER, 4'd3, 31'd10, 32'd0);
      drain();

      // Zero default timeout: a slot hangs as soon as any time passes
      write_csr(CSR_DEFAULT_TIMEOUT, '0);
      write_csr(CSR_ENABLE, 31'd1);
      send_fields(CMD_REGISTER, 4'd0, '0, 32'd100);
      send_fields(CMD_CHECK, 4'd0, '0, 32'd100);
      send_fields(CMD_CHECK, 4'd0, '0, 32'd101);
      send_fields(CMD_REGISTER, 4'd0, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_fields(CMD_UNREGISTER, 4'd0, '0, 32'd102);
      // inactive slot on unregister and pet
      send_fields(CMD_UNREGISTER, 4'd0, '0, 32'd103);
      send_fields(CMD_PET, 4'd9, '0, 32'd104);
      // wrapped time: just past and exactly at the largest timeout
      send_fields(CMD_PET, 4'd1, '0, 32'h0000_0005);
      send_fields(CMD_CHECK, 4'hF, '0, 32'h8000_0005);
      send_fields(CMD_CHECK, 4'd0, '0, 32'h8000_0004);
      // fill the table, then one register too many
      for (int k = 0; k < MSW_SLOTS; k++)
         send_fields(CMD_REGISTER, 4'hF, (k == 2) ? 31'h7FFF_FFFF : TMO_W'($urandom_range(1, 9)),
                     TIME_W'($urandom));
      send_fields(CMD_CHECK, 4'd0, '0, 32'hFFFF_FFFF);

      // Random phases; most set a new default timeout and some change the enable
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            0: write_csr(CSR_DEFAULT_TIMEOUT, 31'd1);
            1: write_csr(CSR_DEFAULT_TIMEOUT, 31'h7FFF_FFFF);
            2: write_csr(CSR_DEFAULT_TIMEOUT, '0);
            4: write_csr(CSR_DEFAULT_TIMEOUT, TMO_W'($urandom_range(1, 500)));
            5: write_csr(CSR_DEFAULT_TIMEOUT, 31'd5000);
            6: write_csr(CSR_DEFAULT_TIMEOUT, TMO_W'($urandom));
            7: write_csr(CSR_DEFAULT_TIMEOUT, 31'd20);
            default: ;
         endcase
         if (phase == 3) write_csr(CSR_ENABLE, '0);
         else if (phase % 3 == 0 || phase == 4) write_csr(CSR_ENABLE, 31'd1);
         // cross the 32-bit wrap in some phases
         if (phase == 1 || phase == 5) now_tick = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 2000));
         else now_tick = TIME_W'($urandom);
         items = (phase == 3) ? 40 : 100;
         burst_left = 0;
         for (int k = 0; k < items; k++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
            end
            if ($urandom_range(0, 59) == 0) drain();
            send_random();
            burst_left--;
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
design/msw_pkg.sv
design/msw_table.sv
design/msw_ctrl.sv
design/multi_slot_heartbeat_watchdog.sv
bench/tb.sv
